[hdl/tcfe_pkg.sv]
package tcfe_pkg;

	localparam int unsigned CacheEntriesDef = 16;
	localparam int unsigned CoordW = 16;
	localparam int unsigned SlotW = 4;
	localparam int unsigned DistW = 18;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		logic   hit;
		logic [SlotW-1:0] slot;
		logic   evicted;
		coord_t evicted_x;
		coord_t evicted_z;
	} result_t;

	typedef struct packed {
		coord_t tile_x;
		coord_t tile_z;
		coord_t center_x;
		coord_t center_z;
	} request_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} state_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic   shift;
		logic   write;
		coord_t wr_col;
		coord_t wr_row;
	} cell_ctrl_t;

	function automatic logic [DistW-1:0] abs_diff(coord_t a, coord_t b);
		logic signed [CoordW:0] d;
		d = {a[CoordW-1], a} - {b[CoordW-1], b};
		return d[CoordW] ? DistW'(-d) : DistW'(d);
	endfunction

endpackage

[hdl/tcfe_stream_if.sv]
interface tcfe_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/tcfe_cell.sv]
// One cache slot. The entries form a rotating ring: on shift every cell takes
// its neighbor's contents, so the head cell presents each entry in turn.
module tcfe_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tcfe_pkg::cell_ctrl_t ctrl,
	input  logic                is_target,
	input  logic                prev_valid,
	input  tcfe_pkg::coord_t    prev_col,
	input  tcfe_pkg::coord_t    prev_row,
	output logic                valid,
	output tcfe_pkg::coord_t    col,
	output tcfe_pkg::coord_t    row
);
	logic             valid_q;
	tcfe_pkg::coord_t col_q;
	tcfe_pkg::coord_t row_q;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= prev_valid;
		end else if (ctrl.write && is_target) begin
			valid_q <= 1'b1;
		end
	end

	// coordinates
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			col_q <= prev_col;
			row_q <= prev_row;
		end else if (ctrl.write && is_target) begin
			col_q <= ctrl.wr_col;
			row_q <= ctrl.wr_row;
		end
	end

	assign valid = valid_q;
	assign col   = col_q;
	assign row   = row_q;
endmodule

[hdl/tile_cache_farthest_eviction_top.sv]
// Channel  Dir  Payload                                   Handshake
// req      in   tile_x, tile_z, center_x, center_z        valid/ready
// rsp      out  hit, slot, evicted, evicted_x, evicted_z  valid/ready
//
// A request is captured first; the cell ring then rotates each entry past the
// head cell in turn, and a write step fills the target slot on a miss;
// the result then sits in the output register until taken.
// The ring ends each scan back in its original order. Reset clears all
// valid bits at once. A stalled response holds the next request off.
module tile_cache_farthest_eviction_top #(
	parameter int unsigned CACHE_ENTRIES = tcfe_pkg::CacheEntriesDef
) (
	input  logic clk,
	input  logic arst_n,
	tcfe_stream_if.sink   req,
	tcfe_stream_if.source rsp
);
	localparam int unsigned IdxW = $clog2(CACHE_ENTRIES);

	tcfe_pkg::state_t     state_q, state_d;
	tcfe_pkg::request_t   req_q;
	tcfe_pkg::result_t    rsp_q;
	logic [IdxW-1:0]      cnt_q;
	logic                 hit_q, empty_q, best_q;
	logic [IdxW-1:0]      hit_idx_q, empty_idx_q, best_idx_q;
	logic [tcfe_pkg::DistW-1:0] best_d_q;
	tcfe_pkg::coord_t     best_col_q, best_row_q;
	tcfe_pkg::cell_ctrl_t ctrl;
	logic [IdxW-1:0]      target;

	logic                 v   [CACHE_ENTRIES];
	tcfe_pkg::coord_t     c   [CACHE_ENTRIES];
	tcfe_pkg::coord_t     r   [CACHE_ENTRIES];

	// cell ring: cell i takes from cell i+1, head cell 0 is examined
	for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
		localparam int unsigned Nx = (i + 1) % CACHE_ENTRIES;
		tcfe_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.is_target  (target == IdxW'(i)),
			.prev_valid (v[Nx]),
			.prev_col   (c[Nx]),
			.prev_row   (r[Nx]),
			.valid      (v[i]),
			.col        (c[i]),
			.row        (r[i])
		);
	end

	// Manhattan distance of the head entry from the center
	logic [tcfe_pkg::DistW-1:0] span_sum;
	assign span_sum = tcfe_pkg::abs_diff(c[0], req_q.center_x)
		+ tcfe_pkg::abs_diff(r[0], req_q.center_z);

	assign target = hit_q ? hit_idx_q : (empty_q ? empty_idx_q : best_idx_q);

	// next state and control
	always_comb begin
		state_d     = state_q;
		ctrl.shift  = 1'b0;
		ctrl.write  = 1'b0;
		ctrl.wr_col = req_q.tile_x;
		ctrl.wr_row = req_q.tile_z;
		unique case (state_q)
			tcfe_pkg::ST_IDLE: begin
				if (req.valid) state_d = tcfe_pkg::ST_SCAN;
			end
			tcfe_pkg::ST_SCAN: begin
				ctrl.shift = 1'b1;
				if (cnt_q == IdxW'(CACHE_ENTRIES - 1)) state_d = tcfe_pkg::ST_WRITE;
			end
			tcfe_pkg::ST_WRITE: begin
				ctrl.write = !hit_q;
				state_d    = tcfe_pkg::ST_OUT;
			end
			tcfe_pkg::ST_OUT: begin
				if (rsp.ready) state_d = tcfe_pkg::ST_IDLE;
			end
			default: state_d = tcfe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tcfe_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
			best_q  <= 1'b0;
		end else if (state_q == tcfe_pkg::ST_IDLE) begin
			cnt_q   <= '0;
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
			best_q  <= 1'b0;
		end else if (state_q == tcfe_pkg::ST_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
			if (v[0] && !hit_q && c[0] == req_q.tile_x && r[0] == req_q.tile_z)
				hit_q <= 1'b1;
			if (!v[0] && !empty_q) empty_q <= 1'b1;
			if (!best_q || span_sum > best_d_q) best_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcfe_pkg::ST_IDLE && req.valid) req_q <= req.data;
		if (state_q == tcfe_pkg::ST_SCAN) begin
			if (v[0] && !hit_q && c[0] == req_q.tile_x && r[0] == req_q.tile_z)
				hit_idx_q <= cnt_q;
			if (!v[0] && !empty_q) empty_idx_q <= cnt_q;
			if (!best_q || span_sum > best_d_q) begin
				best_d_q   <= span_sum;
				best_idx_q <= cnt_q;
				best_col_q <= c[0];
				best_row_q <= r[0];
			end
		end
		if (state_q == tcfe_pkg::ST_WRITE) begin
			rsp_q.hit       <= hit_q;
			rsp_q.slot      <= tcfe_pkg::SlotW'(32'(target));
			rsp_q.evicted   <= !hit_q && !empty_q;
			rsp_q.evicted_x <= (!hit_q && !empty_q) ? best_col_q : '0;
			rsp_q.evicted_z <= (!hit_q && !empty_q) ? best_row_q : '0;
		end
	end

	assign req.ready = (state_q == tcfe_pkg::ST_IDLE);
	assign rsp.valid = (state_q == tcfe_pkg::ST_OUT);
	assign rsp.data  = rsp_q;

	// assertions
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("request and response overlap");
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcfe_pkg::ST_WRITE) |-> $past(cnt_q) == IdxW'(CACHE_ENTRIES - 1))
		else $error("scan length wrong");
	a_no_evict_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp_q.hit && rsp_q.evicted)) else $error("hit with eviction");
endmodule
